// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file qdt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qdt_pkg.sv =====
package qdt_pkg;

  localparam int MAX_TILES       = 8192;
  localparam int TILE_SIDE       = 16;
  localparam int PIXELS_PER_WORD = 4;

  localparam int TILE_PIX       = TILE_SIDE * TILE_SIDE;
  localparam int WORDS_PER_TILE = TILE_PIX / PIXELS_PER_WORD;
  localparam int LANES          = PIXELS_PER_WORD;
  localparam int WORD_W         = $clog2(WORDS_PER_TILE);
  localparam int POS_W          = $clog2(MAX_TILES);
  localparam int TOTAL_W        = $clog2(MAX_TILES + 1);
  localparam int PREV_AW        = POS_W + WORD_W;
  localparam int PREV_DEPTH     = MAX_TILES * WORDS_PER_TILE;

  localparam int PIX_W      = 24;
  localparam int BYTE_W     = 8;
  localparam int TILE_NUM_W = 13;
  localparam int IN_DATA_W  = LANES * PIX_W;
  localparam int OUT_DATA_W = ((TILE_NUM_W + LANES * PIX_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - TILE_NUM_W - LANES * PIX_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN    = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic               start;
    logic               finish;
    logic               clr;
    logic [PREV_AW-1:0] addr;
    logic               rd_en;
    logic [WORD_W-1:0]  rd_addr;
  } lane_ctrl_t;

  typedef struct packed {
    logic [TILE_NUM_W-1:0] tile_number;
    logic                  tile_changed;
    logic                  data_valid;
    logic                  last;
  } out_meta_t;

  // four restoring-division steps; returns {remainder, quotient nibble}
  function automatic logic [BYTE_W+3:0] div_nibble(input logic [BYTE_W-1:0] rem_in,
                                                   input logic [3:0] bits,
                                                   input logic [BYTE_W-1:0] d);
    logic [BYTE_W:0] r;
    logic [3:0]      q;
    r = {1'b0, rem_in};
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[BYTE_W-1:0], bits[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return {r[BYTE_W-1:0], q};
  endfunction

endpackage

// ===== hdl/qdt_lane.sv =====
module qdt_lane (
  input  logic                clk,
  input  qdt_pkg::lane_ctrl_t ctrl,
  input  qdt_pkg::pixel_t     pixel,
  input  logic [7:0]          div,
  output logic                diff,
  output qdt_pkg::pixel_t     tile_q
);
  import qdt_pkg::*;

  pixel_t                  pix;
  logic [2:0][BYTE_W-1:0]  rem_hi;
  logic [2:0][3:0]         q_hi;
  pixel_t                  prev_q;
  logic [PREV_AW-1:0]      addr_reg;

  logic [2:0][BYTE_W-1:0]  rem_a;
  logic [2:0][3:0]         q_a;
  pixel_t                  q;

  pixel_t prev_mem [PREV_DEPTH];
  pixel_t tile_mem [WORDS_PER_TILE];

  logic               wr_en;
  logic [PREV_AW-1:0] wr_addr;
  pixel_t             wr_data;

  always_comb begin
    logic [BYTE_W+3:0] s;
    for (int b = 0; b < 3; b++) begin
      s        = div_nibble('0, pixel[b*BYTE_W+4 +: 4], div);
      rem_a[b] = s[BYTE_W+3:4];
      q_a[b]   = s[3:0];
    end
  end

  always_comb begin
    logic [BYTE_W+3:0] s;
    for (int b = 0; b < 3; b++) begin
      s = div_nibble(rem_hi[b], pix[b*BYTE_W +: 4], div);
      if (pix[b*BYTE_W +: BYTE_W] == '0) begin
        q[b*BYTE_W +: BYTE_W] = BYTE_W'(1);
      end else begin
        q[b*BYTE_W +: BYTE_W] = {q_hi[b], s[3:0]};
      end
    end
  end

  assign diff = (q != prev_q);

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pix      <= pixel;
      rem_hi   <= rem_a;
      q_hi     <= q_a;
      addr_reg <= ctrl.addr;
      prev_q   <= prev_mem[ctrl.addr];
    end
  end

  assign wr_en   = ctrl.finish | ctrl.clr;
  assign wr_addr = ctrl.clr ? ctrl.addr : addr_reg;
  assign wr_data = ctrl.clr ? '0 : q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      tile_mem[addr_reg[WORD_W-1:0]] <= q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      tile_q <= tile_mem[ctrl.rd_addr];
    end
  end

endmodule

// ===== hdl/qdt_merge.sv =====
module qdt_merge (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [qdt_pkg::LANES-1:0]               lane_diff,
  input  logic                                    acc,
  input  logic                                    tile_end,
  input  logic                                    clr,
  output logic                                    dirty_now,
  input  logic                                    s1_load,
  input  qdt_pkg::out_meta_t                      meta,
  input  qdt_pkg::pixel_t [qdt_pkg::LANES-1:0]    lane_q,
  output logic                                    s1_ready,
  output logic                                    tvalid,
  input  logic                                    tready,
  output logic [qdt_pkg::OUT_DATA_W-1:0]          tdata,
  output logic [1:0]                              tuser,
  output logic                                    tlast
);
  import qdt_pkg::*;

  logic dirty;

  logic                    s1_valid;
  out_meta_t               s1_meta;
  logic                    out_valid;
  out_meta_t               out_meta;
  pixel_t [LANES-1:0]      out_pix;
  logic                    out_free;

  assign dirty_now = dirty | (|lane_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b0;
    end else if (clr) begin
      dirty <= 1'b0;
    end else if (acc) begin
      dirty <= tile_end ? 1'b0 : dirty_now;
    end
  end

  assign out_free = !out_valid || tready;
  assign s1_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_meta <= meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_meta <= s1_meta;
      out_pix  <= s1_meta.data_valid ? lane_q : '0;
    end
  end

  assign tvalid = out_valid;
  assign tdata  = {{OUT_PAD_W{1'b0}}, out_pix, out_meta.tile_number};
  assign tuser  = {out_meta.data_valid, out_meta.tile_changed};
  assign tlast  = out_meta.last;

endmodule

// ===== hdl/quantized_dirty_tile_detector.sv =====
// channel      | dir | handshake                    | payload
// s_axis       | in  | s_axis_tvalid/s_axis_tready  | tdata: pixel_a..pixel_d, tuser: frame_start
// m_axis       | out | m_axis_tvalid/m_axis_tready  | tdata: tile_number, out_pixel_a..d
//              |     |                              | tuser: tile_changed, data_valid; tlast: last
// cfg          | in  | cfg_we                       | cfg_index, cfg_data
//
// Each input word passes ST_IDLE, then ST_WORK, before the next is taken: each lane
// divides every byte high nibble first, then low nibble, and the previous-frame read is
// followed by its write-back on the same memory port. At the end of a tile an unchanged
// tile adds one flag result; a changed tile reads out all 64 tile-store words, one
// tile-store read per cycle while m_axis does not stall. After reset a clearing pass
// zeroes all 524288 previous-frame words (one word of four pixels per cycle); no input is taken until it ends.
module quantized_dirty_tile_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [qdt_pkg::IN_DATA_W-1:0]          s_axis_tdata,  // pixel_a, pixel_b, pixel_c, pixel_d
  input  logic                                   s_axis_tuser,  // frame_start
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [qdt_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // tile_number, out_pixel_a..d, pad
  output logic [1:0]                             m_axis_tuser,  // tile_changed, data_valid
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_we,
  input  logic [qdt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [qdt_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import qdt_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WORK  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [WORD_W-1:0]  WORD_LAST = WORD_W'(WORDS_PER_TILE - 1);
  localparam logic [PREV_AW-1:0] CLR_LAST  = PREV_AW'(PREV_DEPTH - 1);

  logic [1:0]          state;
  logic [PREV_AW-1:0]  clr_addr;
  logic [WORD_W-1:0]   word;
  logic [POS_W-1:0]    pos;
  logic [WORD_W-1:0]   emit_k;
  logic                emit_dirty;
  logic [POS_W-1:0]    emit_tile;

  logic [7:0]          quant_divisor;
  logic [7:0]          tiles_across;
  logic [7:0]          tiles_down;
  logic [TOTAL_W-1:0]  total;

  logic [7:0]          div_eff;
  logic [15:0]         prod;
  logic                accept;
  logic [WORD_W-1:0]   word_eff;
  logic [POS_W-1:0]    pos_eff;
  logic [TOTAL_W-1:0]  pos_inc;
  logic                finish;
  logic                tile_end;
  logic                emit_last;

  lane_ctrl_t          ctrl;
  pixel_t [LANES-1:0]  pixels;
  logic [LANES-1:0]    lane_diff;
  pixel_t [LANES-1:0]  lane_q;
  logic                dirty_now;
  logic                s1_ready;
  logic                s1_load;
  out_meta_t           meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_divisor <= 8'd1;
      tiles_across  <= 8'd1;
      tiles_down    <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUANT_DIVISOR: quant_divisor <= cfg_data;
        CFG_TILES_ACROSS:  tiles_across  <= cfg_data;
        CFG_TILES_DOWN:    tiles_down    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign div_eff = (quant_divisor == '0) ? 8'd1 : quant_divisor;
  assign prod    = 16'(tiles_across) * 16'(tiles_down);

  always_ff @(posedge clk) begin
    if (prod == '0) begin
      total <= TOTAL_W'(1);
    end else if (prod > 16'(MAX_TILES)) begin
      total <= TOTAL_W'(MAX_TILES);
    end else begin
      total <= TOTAL_W'(prod);
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign word_eff      = s_axis_tuser ? '0 : word;
  assign pos_eff       = s_axis_tuser ? '0 : pos;
  assign finish        = (state == ST_WORK);
  assign tile_end      = finish && (word == WORD_LAST);
  assign pos_inc       = TOTAL_W'(pos) + TOTAL_W'(1);
  assign s1_load       = (state == ST_EMIT) && s1_ready;
  assign emit_last     = !emit_dirty || (emit_k == WORD_LAST);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pixels[l] = s_axis_tdata[l*PIX_W +: PIX_W];
    end
  end

  always_comb begin
    ctrl.start   = accept;
    ctrl.finish  = finish;
    ctrl.clr     = (state == ST_CLEAR);
    ctrl.addr    = (state == ST_CLEAR) ? clr_addr : {pos_eff, word_eff};
    ctrl.rd_en   = s1_load && emit_dirty;
    ctrl.rd_addr = emit_k;
  end

  always_comb begin
    meta.tile_number  = TILE_NUM_W'(emit_tile);
    meta.tile_changed = emit_dirty;
    meta.data_valid   = emit_dirty;
    meta.last         = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      word     <= '0;
      pos      <= '0;
      emit_k   <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + PREV_AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            word  <= word_eff;
            pos   <= pos_eff;
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (tile_end) begin
            word   <= '0;
            pos    <= (pos_inc >= total) ? '0 : pos_inc[POS_W-1:0];
            emit_k <= '0;
            state  <= ST_EMIT;
          end else begin
            word  <= word + WORD_W'(1);
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (s1_load) begin
            emit_k <= emit_k + WORD_W'(1);
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tile_end) begin
      emit_tile  <= pos;
      emit_dirty <= dirty_now;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    qdt_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .pixel  (pixels[l]),
      .div    (div_eff),
      .diff   (lane_diff[l]),
      .tile_q (lane_q[l])
    );
  end

  qdt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_diff (lane_diff),
    .acc       (finish),
    .tile_end  (tile_end),
    .clr       (accept && s_axis_tuser),
    .dirty_now (dirty_now),
    .s1_load   (s1_load),
    .meta      (meta),
    .lane_q    (lane_q),
    .s1_ready  (s1_ready),
    .tvalid    (m_axis_tvalid),
    .tready    (m_axis_tready),
    .tdata     (m_axis_tdata),
    .tuser     (m_axis_tuser),
    .tlast     (m_axis_tlast)
  );

endmodule

// ===== hdl/qdt_checker.sv =====
`include "assert_macros.svh"

module qdt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);
  import qdt_pkg::*;

  // a flag result closes its tile by itself
  `ASSERT_SAME(a_flag_last, clk, rst, m_axis_tvalid && !m_axis_tuser[1], m_axis_tlast, "flag result without tlast")

  `ASSERT_SAME(a_changed_data, clk, rst, m_axis_tvalid, m_axis_tuser[0] == m_axis_tuser[1], "tile_changed and data_valid disagree")

  `ASSERT_SAME(a_flag_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[OUT_DATA_W-1:TILE_NUM_W] == '0, "flag result carries pixel data")

  // hold a stalled transfer
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind quantized_dirty_tile_detector qdt_checker u_qdt_checker (.*);
